>>> rtl/pcc_pkg.sv
// Package for the paper computer processor: request modes, opcodes, decode
// types, state encoding and the memory access struct. No dependencies.
`default_nettype none

package pcc_pkg;

  localparam int unsigned AddrW = 8;
  localparam int unsigned DataW = 8;
  localparam int unsigned MemDepth = 1 << AddrW;

  localparam logic [DataW-1:0] PcReset = 8'd32;

  // Request modes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SETPC = 2'd1;
  localparam logic [1:0] MODE_EXEC  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Opcodes.
  localparam logic [7:0] OP_LOAD_IMM  = 8'd0;
  localparam logic [7:0] OP_JUMP      = 8'd16;
  localparam logic [7:0] OP_BRN       = 8'd17;
  localparam logic [7:0] OP_BRZ       = 8'd18;
  localparam logic [7:0] OP_ADD_IMM   = 8'd32;
  localparam logic [7:0] OP_SUB_IMM   = 8'd33;
  localparam logic [7:0] OP_NAND_IMM  = 8'd34;
  localparam logic [7:0] OP_LOAD_DIR  = 8'd64;
  localparam logic [7:0] OP_OUT_DIR   = 8'd65;
  localparam logic [7:0] OP_STORE_DIR = 8'd72;
  localparam logic [7:0] OP_IN_DIR    = 8'd73;
  localparam logic [7:0] OP_ADD_DIR   = 8'd96;
  localparam logic [7:0] OP_SUB_DIR   = 8'd97;
  localparam logic [7:0] OP_NAND_DIR  = 8'd98;
  localparam logic [7:0] OP_LOAD_IND  = 8'd192;
  localparam logic [7:0] OP_OUT_IND   = 8'd193;
  localparam logic [7:0] OP_STORE_IND = 8'd200;
  localparam logic [7:0] OP_IN_IND    = 8'd201;
  localparam logic [7:0] OP_ADD_IND   = 8'd224;
  localparam logic [7:0] OP_SUB_IND   = 8'd225;
  localparam logic [7:0] OP_NAND_IND  = 8'd226;

  typedef enum logic [3:0] {
    K_LOAD, K_ADD, K_SUB, K_NAND, K_OUT, K_STORE, K_IN,
    K_JUMP, K_BRN, K_BRZ, K_BAD
  } kind_e;

  typedef enum logic [1:0] {
    AM_IMM, AM_DIR, AM_IND
  } amode_e;

  typedef struct packed {
    kind_e  kind;
    amode_e amode;
  } dec_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ARG, ST_PTR, ST_OPND, ST_IND, ST_RD, ST_DONE
  } state_e;

  // One access to the single-port memory.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

  // Splits an opcode byte into its operation and its operand addressing.
  function automatic dec_t pcc_decode(input logic [7:0] op);
    dec_t d;
    d = '{kind: K_BAD, amode: AM_IMM};
    case (op)
      OP_LOAD_IMM:  d = '{kind: K_LOAD,  amode: AM_IMM};
      OP_JUMP:      d = '{kind: K_JUMP,  amode: AM_IMM};
      OP_BRN:       d = '{kind: K_BRN,   amode: AM_IMM};
      OP_BRZ:       d = '{kind: K_BRZ,   amode: AM_IMM};
      OP_ADD_IMM:   d = '{kind: K_ADD,   amode: AM_IMM};
      OP_SUB_IMM:   d = '{kind: K_SUB,   amode: AM_IMM};
      OP_NAND_IMM:  d = '{kind: K_NAND,  amode: AM_IMM};
      OP_LOAD_DIR:  d = '{kind: K_LOAD,  amode: AM_DIR};
      OP_OUT_DIR:   d = '{kind: K_OUT,   amode: AM_DIR};
      OP_STORE_DIR: d = '{kind: K_STORE, amode: AM_DIR};
      OP_IN_DIR:    d = '{kind: K_IN,    amode: AM_DIR};
      OP_ADD_DIR:   d = '{kind: K_ADD,   amode: AM_DIR};
      OP_SUB_DIR:   d = '{kind: K_SUB,   amode: AM_DIR};
      OP_NAND_DIR:  d = '{kind: K_NAND,  amode: AM_DIR};
      OP_LOAD_IND:  d = '{kind: K_LOAD,  amode: AM_IND};
      OP_OUT_IND:   d = '{kind: K_OUT,   amode: AM_IND};
      OP_STORE_IND: d = '{kind: K_STORE, amode: AM_IND};
      OP_IN_IND:    d = '{kind: K_IN,    amode: AM_IND};
      OP_ADD_IND:   d = '{kind: K_ADD,   amode: AM_IND};
      OP_SUB_IND:   d = '{kind: K_SUB,   amode: AM_IND};
      OP_NAND_IND:  d = '{kind: K_NAND,  amode: AM_IND};
      default:      d = '{kind: K_BAD,   amode: AM_IMM};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcc_if.sv
// Request and response channel interfaces of the paper computer processor.
// Each carries valid, ready and its payload; no package dependency.
`default_nettype none

interface pcc_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [7:0]        addr;
  logic [7:0]        data;
  logic signed [7:0] in_value;

  modport source (output valid, mode, addr, data, in_value, input ready);
  modport sink   (input valid, mode, addr, data, in_value, output ready);
endinterface

interface pcc_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] acc;
  logic [7:0]        pc;
  logic              out_valid;
  logic signed [7:0] out_value;
  logic              input_taken;
  logic [7:0]        read_data;
  logic              fault;

  modport source (output valid, acc, pc, out_valid, out_value, input_taken, read_data,
                  fault, input ready);
  modport sink   (input valid, acc, pc, out_valid, out_value, input_taken, read_data,
                  fault, output ready);
endinterface

`default_nettype wire

>>> rtl/pcc_mem.sv
// Single-port 256-byte synchronous memory with a registered read port.
// Depends on pcc_pkg for the access struct and sizes.
`default_nettype none

module pcc_mem (
  input  logic                          clk_i,
  input  pcc_pkg::mem_req_t             mem_i,
  output logic [pcc_pkg::DataW-1:0]     rdata_o
);
  import pcc_pkg::*;

  logic [DataW-1:0] mem_q [MemDepth];
  logic [DataW-1:0] rdata_q;

  // Read-first access: the old contents appear on the read port in the next cycle.
  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.addr] <= mem_i.wdata;
    end
    rdata_q <= mem_q[mem_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/pcc_seq.sv
// Sequencer and datapath of the paper computer processor: handshakes,
// accumulator, program counter, halt flag and memory access order.
// Depends on pcc_pkg and the channel interfaces in pcc_if.
`default_nettype none

module pcc_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pcc_req_if.sink                   req_i,
  pcc_rsp_if.source                 rsp_o,
  output pcc_pkg::mem_req_t         mem_o,
  input  logic [pcc_pkg::DataW-1:0] mem_rdata_i,
  output pcc_pkg::state_e           state_o
);
  import pcc_pkg::*;

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [AddrW-1:0] pc_q, pc_d;
  logic             halted_q, halted_d;
  dec_t             dec_q, dec_d;
  logic [DataW-1:0] arg_q, arg_d;
  logic [DataW-1:0] inval_q, inval_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  logic             input_taken_q, input_taken_d;
  logic [DataW-1:0] read_data_q, read_data_d;
  logic             accept;

  assign accept = req_i.valid && req_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AddrW'(MemDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_READ: state_d = ST_RD;
            MODE_EXEC: state_d = halted_q ? ST_DONE : ST_ARG;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_ARG:  state_d = ST_PTR;
      ST_PTR:  state_d = ST_OPND;
      ST_OPND: state_d = (dec_q.amode == AM_IND) ? ST_IND : ST_DONE;
      ST_IND:  state_d = ST_DONE;
      ST_RD:   state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory accesses and datapath updates.
  always_comb begin
    logic             exec_en;
    logic [DataW-1:0] opnd;
    logic             is_store;
    logic [DataW-1:0] st_data;

    exec_en       = 1'b0;
    opnd          = mem_rdata_i;
    is_store      = (dec_q.kind == K_STORE) || (dec_q.kind == K_IN);
    st_data       = (dec_q.kind == K_IN) ? inval_q : acc_q;
    mem_o         = '{we: 1'b0, addr: pc_q, wdata: '0};
    clr_d         = clr_q;
    acc_d         = acc_q;
    pc_d          = pc_q;
    halted_d      = halted_q;
    dec_d         = dec_q;
    arg_d         = arg_q;
    inval_d       = inval_q;
    out_valid_d   = out_valid_q;
    out_value_d   = out_value_q;
    input_taken_d = input_taken_q;
    read_data_d   = read_data_q;

    case (state_q)
      // Clearing pass: one byte per cycle after reset.
      ST_CLEAR: begin
        mem_o = '{we: 1'b1, addr: clr_q, wdata: '0};
        clr_d = clr_q + AddrW'(1);
      end
      // Writes happen at acceptance; reads and opcode fetch are issued here.
      ST_IDLE: begin
        mem_o.addr  = (req_i.mode == MODE_EXEC) ? pc_q : req_i.addr;
        mem_o.we    = accept && (req_i.mode == MODE_WRITE);
        mem_o.wdata = req_i.data;
        if (accept) begin
          out_valid_d   = 1'b0;
          out_value_d   = '0;
          input_taken_d = 1'b0;
          read_data_d   = '0;
          inval_d       = req_i.in_value;
          if (req_i.mode == MODE_SETPC) begin
            pc_d     = req_i.addr;
            halted_d = 1'b0;
          end
        end
      end
      // Opcode arrives; fetch the argument and advance the PC.
      ST_ARG: begin
        dec_d      = pcc_decode(mem_rdata_i);
        mem_o.addr = pc_q + AddrW'(1);
        pc_d       = pc_q + AddrW'(2);
      end
      // Argument arrives; read the byte it points at.
      ST_PTR: begin
        arg_d      = mem_rdata_i;
        mem_o.addr = mem_rdata_i;
      end
      // memory[arg] arrives: either the operand or the indirect pointer.
      ST_OPND: begin
        if (dec_q.amode == AM_IND) begin
          mem_o = '{we: is_store, addr: mem_rdata_i, wdata: st_data};
        end else begin
          exec_en = 1'b1;
          opnd    = (dec_q.amode == AM_IMM) ? arg_q : mem_rdata_i;
          mem_o   = '{we: is_store, addr: arg_q, wdata: st_data};
        end
      end
      // Indirect operand arrives.
      ST_IND: begin
        exec_en = 1'b1;
      end
      ST_RD: begin
        read_data_d = mem_rdata_i;
      end
      default: begin
      end
    endcase

    // Instruction effect on the registers.
    if (exec_en) begin
      case (dec_q.kind)
        K_LOAD:  acc_d = opnd;
        K_ADD:   acc_d = acc_q + opnd;
        K_SUB:   acc_d = acc_q - opnd;
        K_NAND:  acc_d = ~(acc_q & opnd);
        K_OUT: begin
          out_valid_d = 1'b1;
          out_value_d = opnd;
        end
        K_IN:    input_taken_d = 1'b1;
        K_STORE: begin
        end
        K_JUMP:  pc_d = arg_q;
        K_BRN:   if (acc_q[DataW-1]) pc_d = arg_q;
        K_BRZ:   if (acc_q == '0) pc_d = arg_q;
        default: halted_d = 1'b1;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      acc_q    <= '0;
      pc_q     <= PcReset;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      acc_q    <= acc_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
    end
  end

  // Per-request payload registers.
  always_ff @(posedge clk_i) begin
    dec_q         <= dec_d;
    arg_q         <= arg_d;
    inval_q       <= inval_d;
    out_valid_q   <= out_valid_d;
    out_value_q   <= out_value_d;
    input_taken_q <= input_taken_d;
    read_data_q   <= read_data_d;
  end

  // Channel outputs.
  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = (state_q == ST_DONE);
  assign rsp_o.acc         = acc_q;
  assign rsp_o.pc          = pc_q;
  assign rsp_o.out_valid   = out_valid_q;
  assign rsp_o.out_value   = out_value_q;
  assign rsp_o.input_taken = input_taken_q;
  assign rsp_o.read_data   = read_data_q;
  assign rsp_o.fault       = halted_q;
  assign state_o           = state_q;

endmodule

`default_nettype wire

>>> rtl/paper_computer_cpu.sv
// Top level of the 8-bit paper computer accumulator processor.
// Depends on pcc_pkg, pcc_if, pcc_mem and pcc_seq.
//
//   Channel   Direction  Handshake        Payload
//   req_i     in         valid / ready    mode, addr, data, in_value
//   rsp_o     out        valid / ready    acc, pc, out_valid, out_value, input_taken,
//                                         read_data, fault
//
// One request at a time; the single memory port sets the latency. From
// acceptance to a valid response: write, set pc and execute while halted go
// straight to ST_DONE, read passes ST_RD, execute passes ST_ARG, ST_PTR and
// ST_OPND, and ST_IND too if indirect; ST_IDLE follows each response.
// After reset the whole memory is cleared before ready rises.
// A stalled response holds all state and blocks the next request.
`default_nettype none

module paper_computer_cpu (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_req_if.sink   req_i,
  pcc_rsp_if.source rsp_o
);
  import pcc_pkg::*;

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  state_e           state;

  pcc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .state_o     (state)
  );

  pcc_mem u_mem (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Only one request is in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a response is pending");

  // Set pc answers next cycle with the new pc and the halt cleared.
  a_setpc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.mode == MODE_SETPC) |=>
      (rsp_o.valid && !rsp_o.fault && rsp_o.pc == $past(req_i.addr)))
    else $error("set pc response wrong");

  // An instruction either emits or consumes a value, never both.
  a_out_in_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.out_valid && rsp_o.input_taken))
    else $error("out and in flagged together");

  // The memory is only written while clearing, on a write request or by a store or input instruction.
  a_mem_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state == ST_CLEAR || state == ST_OPND || state == ST_IND ||
                    (state == ST_IDLE && req_i.valid && req_i.mode == MODE_WRITE)))
    else $error("unexpected memory write");

endmodule

`default_nettype wire

>>> bench/tb_paper_computer_cpu.sv
// Testbench for the paper computer processor: drives requests, predicts each
// response with a shadow model of memory, accumulator, PC and halt flag.
// Depends on pcc_pkg, the pcc_req_if / pcc_rsp_if interfaces and paper_computer_cpu.
`default_nettype none

module tb_paper_computer_cpu;
  import pcc_pkg::*;

  localparam int NumItems    = 1550;
  localparam int CycleLimit  = 400000;
  localparam int IdlePct     = 15;
  localparam int HoldAt      = 300;
  localparam int HoldCycles  = 300;
  localparam int QuietFirst  = 1000;
  localparam int QuietLast   = 1300;
  localparam int MidDrainAt  = 800;
  localparam int SettleCycles = 8;

  localparam logic [7:0] KNOWN_OPS [21] = '{
    OP_LOAD_IMM, OP_JUMP, OP_BRN, OP_BRZ, OP_ADD_IMM, OP_SUB_IMM, OP_NAND_IMM,
    OP_LOAD_DIR, OP_OUT_DIR, OP_STORE_DIR, OP_IN_DIR, OP_ADD_DIR, OP_SUB_DIR,
    OP_NAND_DIR, OP_LOAD_IND, OP_OUT_IND, OP_STORE_IND, OP_IN_IND, OP_ADD_IND,
    OP_SUB_IND, OP_NAND_IND
  };

  // One response as seen on the output channel.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] pc;
    logic       out_valid;
    logic [7:0] out_value;
    logic       input_taken;
    logic [7:0] read_data;
    logic       fault;
  } cpu_rsp_t;

  // Shadow copy of the processor state and the responses still owed.
  class cpu_shadow;
    bit [7:0] mem [256];
    bit [7:0] acc;
    bit [7:0] pc;
    bit       halted;
    cpu_rsp_t owed_rsps [$];
    int       mismatches;

    function new();
      foreach (mem[i]) mem[i] = 8'd0;
      acc = 8'd0;
      pc = PcReset;
      halted = 1'b0;
      mismatches = 0;
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function void note_request(bit [1:0] mode, bit [7:0] addr, bit [7:0] data,
                               bit [7:0] in_val);
      cpu_rsp_t e;
      bit [7:0] op, arg, ind, arg_addr;
      e = '0;
      case (mode)
        MODE_WRITE: mem[addr] = data;
        MODE_SETPC: begin
          pc = addr;
          halted = 1'b0;
        end
        MODE_READ: e.read_data = mem[addr];
        default: begin
          if (!halted) begin
            arg_addr = pc + 8'd1;
            op = mem[pc];
            arg = mem[arg_addr];
            ind = mem[arg];
            pc = pc + 8'd2;
            case (op)
              OP_LOAD_IMM:  acc = arg;
              OP_JUMP:      pc = arg;
              OP_BRN:       if (acc[7]) pc = arg;
              OP_BRZ:       if (acc == 8'd0) pc = arg;
              OP_ADD_IMM:   acc = acc + arg;
              OP_SUB_IMM:   acc = acc - arg;
              OP_NAND_IMM:  acc = ~(acc & arg);
              OP_LOAD_DIR:  acc = mem[arg];
              OP_OUT_DIR: begin
                e.out_valid = 1'b1;
                e.out_value = mem[arg];
              end
              OP_STORE_DIR: mem[arg] = acc;
              OP_IN_DIR: begin
                mem[arg] = in_val;
                e.input_taken = 1'b1;
              end
              OP_ADD_DIR:   acc = acc + mem[arg];
              OP_SUB_DIR:   acc = acc - mem[arg];
              OP_NAND_DIR:  acc = ~(acc & mem[arg]);
              OP_LOAD_IND:  acc = mem[ind];
              OP_OUT_IND: begin
                e.out_valid = 1'b1;
                e.out_value = mem[ind];
              end
              OP_STORE_IND: mem[ind] = acc;
              OP_IN_IND: begin
                mem[ind] = in_val;
                e.input_taken = 1'b1;
              end
              OP_ADD_IND:   acc = acc + mem[ind];
              OP_SUB_IND:   acc = acc - mem[ind];
              OP_NAND_IND:  acc = ~(acc & mem[ind]);
              default:      halted = 1'b1;
            endcase
          end
        end
      endcase
      e.acc = acc;
      e.pc = pc;
      e.fault = halted;
      owed_rsps.push_back(e);
    endfunction

    // Compares one accepted response with the oldest owed one.
    function void check_response(cpu_rsp_t got);
      cpu_rsp_t e;
      if (owed_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: acc=%0d pc=%0d", $signed(got.acc), got.pc);
        return;
      end
      e = owed_rsps.pop_front();
      if (got.acc !== e.acc || got.pc !== e.pc || got.out_valid !== e.out_valid ||
          got.out_value !== e.out_value || got.input_taken !== e.input_taken ||
          got.read_data !== e.read_data || got.fault !== e.fault) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: acc=%0d pc=%0d out=%0d/%0d in_taken=%0d rd=%0d fault=%0d",
                   $signed(e.acc), e.pc, e.out_valid, $signed(e.out_value),
                   e.input_taken, e.read_data, e.fault);
          $display("         actual:   acc=%0d pc=%0d out=%0d/%0d in_taken=%0d rd=%0d fault=%0d",
                   $signed(got.acc), got.pc, got.out_valid, $signed(got.out_value),
                   got.input_taken, got.read_data, got.fault);
        end
      end
    endfunction

    function int pending();
      return owed_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   items_sent;
  int   rsps_seen;
  int   cycle_count = 0;

  pcc_req_if req_if ();
  pcc_rsp_if rsp_if ();

  cpu_shadow shadow = new();

  paper_computer_cpu u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Response side: checks accepted responses, stalls at random and once for long.
  initial begin
    int hold_left;
    cpu_rsp_t got;
    hold_left = 0;
    rsps_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.acc = rsp_if.acc;
        got.pc = rsp_if.pc;
        got.out_valid = rsp_if.out_valid;
        got.out_value = rsp_if.out_value;
        got.input_taken = rsp_if.input_taken;
        got.read_data = rsp_if.read_data;
        got.fault = rsp_if.fault;
        shadow.check_response(got);
        rsps_seen++;
        if (rsps_seen == HoldAt) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsps_seen >= QuietFirst && rsps_seen < QuietLast) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Offers one request, with a random gap first, and waits until it is taken.
  task automatic send_request(bit [1:0] mode, bit [7:0] addr, bit [7:0] data,
                              bit [7:0] in_val);
    while (!(items_sent >= QuietFirst && items_sent < QuietLast) &&
           $urandom_range(0, 99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.addr <= addr;
    req_if.data <= data;
    req_if.in_value <= in_val;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    shadow.note_request(mode, addr, data, in_val);
    items_sent++;
  endtask

  // Stops offering requests until every owed response has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  function automatic bit [7:0] pick_opcode();
    if ($urandom_range(0, 99) < 88) return KNOWN_OPS[$urandom_range(0, 20)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Writes a short program with operands and pointers, usually points the PC at
  // it and runs it, sometimes reading a touched byte back.
  task automatic run_fragment();
    bit [7:0] base, arg, ptr;
    int n_instr;
    base = 8'($urandom_range(0, 255));
    n_instr = $urandom_range(1, 3);
    for (int k = 0; k < n_instr; k++) begin
      if ($urandom_range(0, 1) == 1) arg = 8'($urandom_range(0, 255));
      else arg = 8'($urandom_range(224, 255));
      send_request(MODE_WRITE, base + 8'(2 * k), pick_opcode(), 8'($urandom));
      send_request(MODE_WRITE, base + 8'(2 * k + 1), arg, 8'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        ptr = 8'($urandom_range(0, 255));
        send_request(MODE_WRITE, arg, ptr, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_request(MODE_WRITE, ptr, 8'($urandom), 8'($urandom));
      end
    end
    if ($urandom_range(0, 9) < 8)
      send_request(MODE_SETPC, base, 8'($urandom), 8'($urandom));
    for (int k = 0; k < n_instr + $urandom_range(0, 1); k++)
      send_request(MODE_EXEC, 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 2) == 0)
      send_request(MODE_READ, arg, 8'($urandom), 8'($urandom));
  endtask

  // Main sequence: reset, directed cases, then random programs and noise.
  initial begin
    bit mid_drained;
    mid_drained = 1'b0;
    items_sent = 0;
    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode <= MODE_WRITE;
    req_if.addr <= 8'd0;
    req_if.data <= 8'd0;
    req_if.in_value <= 8'sd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared memory, and an execute of the all-zero word at the reset PC.
    send_request(MODE_READ, 8'd255, 8'd0, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'd0);
    // Argument fetched across the top of memory, with an add that makes the accumulator negative.
    send_request(MODE_WRITE, 8'd255, OP_ADD_IMM, 8'd0);
    send_request(MODE_WRITE, 8'd0, 8'd255, 8'd0);
    send_request(MODE_SETPC, 8'd255, 8'd0, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'd0);
    // Branch on negative, taken.
    send_request(MODE_WRITE, 8'd1, OP_BRN, 8'd0);
    send_request(MODE_WRITE, 8'd2, 8'd128, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'd0);
    // Indirect input of the most negative value, then output of it.
    send_request(MODE_WRITE, 8'd128, OP_IN_IND, 8'd0);
    send_request(MODE_WRITE, 8'd129, 8'd16, 8'd0);
    send_request(MODE_WRITE, 8'd16, 8'd64, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'h80);
    send_request(MODE_WRITE, 8'd130, OP_OUT_DIR, 8'd0);
    send_request(MODE_WRITE, 8'd131, 8'd64, 8'd0);
    send_request(MODE_EXEC, 8'd255, 8'd255, 8'd0);
    // Unknown opcode halts; execute, write and read while halted.
    send_request(MODE_WRITE, 8'd132, 8'd255, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'd0);
    send_request(MODE_WRITE, 8'd200, 8'd255, 8'd0);
    send_request(MODE_READ, 8'd200, 8'd0, 8'd0);
    // Set PC clears the halt; input of the most positive value.
    send_request(MODE_SETPC, 8'd128, 8'd0, 8'd0);
    send_request(MODE_EXEC, 8'd0, 8'd0, 8'h7F);
    send_request(MODE_READ, 8'd64, 8'd0, 8'd0);
    wait_drained();

    // Random part: mostly well-formed programs, some raw requests.
    while (items_sent < NumItems) begin
      if (!mid_drained && items_sent >= MidDrainAt) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        run_fragment();
      end else begin
        send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                     8'($urandom));
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/pcc_pkg.sv
rtl/pcc_if.sv
rtl/pcc_mem.sv
rtl/pcc_seq.sv
rtl/paper_computer_cpu.sv
bench/tb_paper_computer_cpu.sv
